// ----- rtl/pfp_pkg.sv -----
package pfp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 25;

    localparam logic [7:0] BYTE_OPEN  = 8'h28;
    localparam logic [7:0] BYTE_END   = 8'h22;
    localparam logic [7:0] BYTE_COMMA = 8'h2C;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    localparam logic [7:0] LEAD_LEFT     = 8'h6C;
    localparam logic [7:0] LEAD_RIGHT    = 8'h72;
    localparam logic [7:0] LEAD_NONE     = 8'h6E;
    localparam logic [7:0] LEAD_STOP     = 8'h73;
    localparam logic [7:0] LEAD_DISTANCE = 8'h64;

    typedef enum logic [2:0] {
        CODE_LEFT     = 3'd0,
        CODE_RIGHT    = 3'd1,
        CODE_NONE     = 3'd2,
        CODE_STOP     = 3'd3,
        CODE_DISTANCE = 3'd4
    } pos_code_t;

    typedef enum logic [1:0] {
        PHASE_SKIP   = 2'd0,
        PHASE_DIGITS = 2'd1,
        PHASE_STOP   = 2'd2
    } phase_t;

endpackage

// ----- rtl/position_frame_parser.sv -----
// Position frame parser: takes one received serial byte per beat and answers
// every double-quote byte with one result beat carrying the held position
// code and value. A frame opens with '(', its body is split at the first
// comma: the lead byte (l, r, n, s, d) picks the code, the part after the
// comma is parsed as a signed decimal number wrapped to 16 bits. A body longer
// than MAX_FRAME_BYTES is dropped. The block takes one byte every cycle; a
// quote byte's result is registered after the input register. The input
// stalls only while a quote byte waits behind a stalled, full result register.
module position_frame_parser
    import pfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  position_code,
    output logic [15:0] position_value
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             armed_reg, armed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             comma_reg, comma_next;
    logic [7:0]       lead_reg, lead_next;
    logic             lead_present_reg, lead_present_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [15:0]      accum_reg, accum_next;
    pos_code_t        held_code_reg, held_code_next;
    logic [15:0]      held_value_reg, held_value_next;
    logic             out_valid_reg, out_valid_next;

    logic        is_end;
    logic        fire;
    logic        clear_body;
    logic        is_space;
    logic        is_digit;
    logic [15:0] accum_step;

    assign is_end   = (in_byte_reg == BYTE_END);
    assign in_stall = in_valid_reg && is_end && out_valid_reg && out_stall;
    assign fire     = in_valid_reg && !in_stall;

    assign is_space = (in_byte_reg == BYTE_SPACE)
                   || (in_byte_reg >= BYTE_TAB && in_byte_reg <= BYTE_CR);
    assign is_digit = (in_byte_reg >= BYTE_ZERO) && (in_byte_reg <= BYTE_NINE);
    assign accum_step = {accum_reg[12:0], 3'b000} + {accum_reg[14:0], 1'b0}
                      + {12'd0, in_byte_reg[3:0]};

    assign in_valid_next = in_stall ? in_valid_reg : in_valid;

    always_comb
    begin
        armed_next        = armed_reg;
        count_next        = count_reg;
        comma_next        = comma_reg;
        lead_next         = lead_reg;
        lead_present_next = lead_present_reg;
        phase_next        = phase_reg;
        neg_next          = neg_reg;
        accum_next        = accum_reg;
        held_code_next    = held_code_reg;
        held_value_next   = held_value_reg;
        out_valid_next    = out_stall ? out_valid_reg : 1'b0;
        clear_body        = 1'b0;

        if (fire)
        begin
            if (in_byte_reg == BYTE_OPEN)
            begin
                armed_next = 1'b1;
            end
            else if (is_end)
            begin
                if (lead_present_reg)
                begin
                    unique case (lead_reg)
                        LEAD_LEFT:     held_code_next = CODE_LEFT;
                        LEAD_RIGHT:    held_code_next = CODE_RIGHT;
                        LEAD_NONE:     held_code_next = CODE_NONE;
                        LEAD_STOP:     held_code_next = CODE_STOP;
                        LEAD_DISTANCE: held_code_next = CODE_DISTANCE;
                        default:       held_code_next = held_code_reg;
                    endcase
                end
                if (!(lead_present_reg && lead_reg == LEAD_STOP))
                begin
                    if (!comma_reg)
                    begin
                        held_value_next = 16'd0;
                    end
                    else if (neg_reg)
                    begin
                        held_value_next = ~accum_reg + 16'd1;
                    end
                    else
                    begin
                        held_value_next = accum_reg;
                    end
                end
                armed_next     = 1'b0;
                clear_body     = 1'b1;
                out_valid_next = 1'b1;
            end
            else if (armed_reg)
            begin
                if (count_reg >= MAX_CNT)
                begin
                    // drop an overlong body
                    armed_next = 1'b0;
                    clear_body = 1'b1;
                end
                else
                begin
                    if (comma_reg)
                    begin
                        case (phase_reg)
                            PHASE_SKIP:
                            begin
                                if (is_space)
                                begin
                                    phase_next = PHASE_SKIP;
                                end
                                else if (in_byte_reg == BYTE_PLUS
                                      || in_byte_reg == BYTE_MINUS)
                                begin
                                    neg_next   = (in_byte_reg == BYTE_MINUS);
                                    phase_next = PHASE_DIGITS;
                                end
                                else if (is_digit)
                                begin
                                    accum_next = accum_step;
                                    phase_next = PHASE_DIGITS;
                                end
                                else
                                begin
                                    phase_next = PHASE_STOP;
                                end
                            end
                            PHASE_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    accum_next = accum_step;
                                end
                                else
                                begin
                                    phase_next = PHASE_STOP;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    else if (in_byte_reg == BYTE_COMMA)
                    begin
                        comma_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        lead_next         = in_byte_reg;
                        lead_present_next = 1'b1;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end

        if (clear_body)
        begin
            count_next        = '0;
            comma_next        = 1'b0;
            lead_next         = 8'd0;
            lead_present_next = 1'b0;
            phase_next        = PHASE_SKIP;
            neg_next          = 1'b0;
            accum_next        = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            armed_reg        <= 1'b0;
            count_reg        <= '0;
            comma_reg        <= 1'b0;
            lead_reg         <= 8'd0;
            lead_present_reg <= 1'b0;
            phase_reg        <= PHASE_SKIP;
            neg_reg          <= 1'b0;
            accum_reg        <= 16'd0;
            held_code_reg    <= CODE_LEFT;
            held_value_reg   <= 16'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            armed_reg        <= armed_next;
            count_reg        <= count_next;
            comma_reg        <= comma_next;
            lead_reg         <= lead_next;
            lead_present_reg <= lead_present_next;
            phase_reg        <= phase_next;
            neg_reg          <= neg_next;
            accum_reg        <= accum_next;
            held_code_reg    <= held_code_next;
            held_value_reg   <= held_value_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign out_valid      = out_valid_reg;
    assign position_code  = held_code_reg;
    assign position_value = held_value_reg;

endmodule

// ----- rtl/pfp_checker.sv -----
module pfp_checker
    import pfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  position_code,
    input logic [15:0] position_value
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position_code)
                                   && $stable(position_value))
        else $error("result beat changed while stalled");

    // input backpressure comes only from a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a fresh result follows an accepted quote byte
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && rx_byte == BYTE_END, 2))
        else $error("result without a quote byte");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position_code <= CODE_DISTANCE)
        else $error("position code out of range");

endmodule

bind position_frame_parser pfp_checker u_pfp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .position_code  (position_code),
    .position_value (position_value)
);

// ----- sim/position_frame_parser_tb.sv -----
`timescale 1ns / 1ps

module position_frame_parser_tb;
    import pfp_pkg::*;

    localparam int BODY_LIMIT = MAX_FRAME_BYTES_DEF;

    typedef struct {
        pos_code_t   code;
        logic [15:0] value;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  position_code;
    logic [15:0] position_value;

    int          idle_pct = 26;
    int          bytes_taken = 0;
    int          mismatch_count = 0;
    report_t     expected_reports[$];

    bit          frame_open = 1'b0;
    int          body_len = 0;
    bit          comma_hit = 1'b0;
    logic [7:0]  first_byte = 8'h00;
    bit          first_valid = 1'b0;
    phase_t      num_phase = PHASE_SKIP;
    bit          num_neg = 1'b0;
    logic [15:0] num_acc = 16'd0;
    pos_code_t   hold_code = CODE_LEFT;
    logic [15:0] hold_value = 16'd0;

    position_frame_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .position_code(position_code),
        .position_value(position_value)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("position_frame_parser: mismatch");
        $finish;
    end

    function automatic void drop_body();
        body_len = 0;
        comma_hit = 1'b0;
        first_byte = 8'h00;
        first_valid = 1'b0;
        num_phase = PHASE_SKIP;
        num_neg = 1'b0;
        num_acc = 16'd0;
    endfunction

    function automatic void take_number_byte(input logic [7:0] b);
        if (num_phase == PHASE_SKIP)
        begin
            if (b == BYTE_SPACE || (b >= BYTE_TAB && b <= BYTE_CR))
                return;
            if (b == BYTE_PLUS || b == BYTE_MINUS)
            begin
                num_neg = (b == BYTE_MINUS);
                num_phase = PHASE_DIGITS;
                return;
            end
            num_phase = PHASE_DIGITS;
        end
        if (num_phase == PHASE_DIGITS)
        begin
            if (b >= BYTE_ZERO && b <= BYTE_NINE)
                num_acc = num_acc * 16'd10 + 16'(b - BYTE_ZERO);
            else
                num_phase = PHASE_STOP;
        end
    endfunction

    function automatic bit parse_rx_byte(input logic [7:0] b, output report_t rep);
        rep.code = hold_code;
        rep.value = hold_value;
        if (b == BYTE_OPEN)
        begin
            frame_open = 1'b1;
            return 1'b0;
        end
        if (b == BYTE_END)
        begin
            if (first_valid)
            begin
                case (first_byte)
                    LEAD_LEFT:     hold_code = CODE_LEFT;
                    LEAD_RIGHT:    hold_code = CODE_RIGHT;
                    LEAD_NONE:     hold_code = CODE_NONE;
                    LEAD_STOP:     hold_code = CODE_STOP;
                    LEAD_DISTANCE: hold_code = CODE_DISTANCE;
                    default:       ;
                endcase
            end
            if (!(first_valid && first_byte == LEAD_STOP))
                hold_value = comma_hit ? (num_neg ? -num_acc : num_acc) : 16'd0;
            frame_open = 1'b0;
            drop_body();
            rep.code = hold_code;
            rep.value = hold_value;
            return 1'b1;
        end
        if (frame_open)
        begin
            if (body_len >= BODY_LIMIT)
            begin
                drop_body();
                frame_open = 1'b0;
                return 1'b0;
            end
            if (comma_hit)
                take_number_byte(b);
            else if (b == BYTE_COMMA)
                comma_hit = 1'b1;
            else if (body_len == 0)
            begin
                first_byte = b;
                first_valid = 1'b1;
            end
            body_len++;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        report_t nxt;
        report_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            bytes_taken++;
            if (parse_rx_byte(rx_byte, nxt))
                expected_reports.push_back(nxt);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
                report_mismatch($sformatf("unexpected result code %0d value %0d",
                                          position_code, position_value));
            else
            begin
                want = expected_reports.pop_front();
                if (position_code !== want.code)
                    report_mismatch($sformatf("code got %0d want %0d",
                                              position_code, want.code));
                if (position_value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              position_value, want.value));
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        int taken_mark;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'($urandom);
            @(negedge clk);
        end
        taken_mark = bytes_taken;
        in_valid <= 1'b1;
        rx_byte <= b;
        while (bytes_taken == taken_mark)
            @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] body_noise();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == BYTE_OPEN || b == BYTE_END)
            b = b ^ 8'h80;
        return b;
    endfunction

    function automatic logic [7:0] pick_lead();
        case ($urandom_range(4))
            0:       return LEAD_LEFT;
            1:       return LEAD_RIGHT;
            2:       return LEAD_NONE;
            3:       return LEAD_STOP;
            default: return LEAD_DISTANCE;
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(2))
            0:       return BYTE_SPACE;
            1:       return BYTE_TAB;
            default: return 8'($urandom_range(BYTE_TAB, BYTE_CR));
        endcase
    endfunction

    task automatic send_random_frame();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            send_byte(BYTE_OPEN);
            if ($urandom_range(99) < 80)
                send_byte(pick_lead());
            else if ($urandom_range(1))
                send_byte(8'($urandom));
            if ($urandom_range(99) < 85)
            begin
                send_byte(BYTE_COMMA);
                n = $urandom_range(0, 2);
                repeat (n) send_byte(pick_space());
                case ($urandom_range(2))
                    0:       send_byte(BYTE_PLUS);
                    1:       send_byte(BYTE_MINUS);
                    default: ;
                endcase
                n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
                repeat (n) send_byte(BYTE_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(99) < 20)
                send_byte(8'($urandom));
            send_byte(BYTE_END);
        end
        else if (kind < 80)
        begin
            send_byte(BYTE_OPEN);
            n = $urandom_range(BODY_LIMIT - 1, BODY_LIMIT + 3);
            repeat (n) send_byte(body_noise());
            send_byte(BYTE_END);
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom));
        end
        else
        begin
            send_byte(BYTE_OPEN);
            send_byte(pick_lead());
            send_byte(BYTE_COMMA);
            n = $urandom_range(1, 4);
            repeat (n) send_byte(BYTE_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic test_directed_frames();
        int i;
        idle_pct = 26;
        send_byte(BYTE_END);
        send_text("(l,123\"");
        send_text("(r,-45\"");
        send_text("(n\"");
        send_text("(d,+65535\"");
        send_text("(s,999\"");
        send_text("(x,7\"");
        send_text("(,300\"");
        send_text("(d,70000\"");
        send_text("(d,-0\"");
        send_text("(r, \t\n");
        send_byte(BYTE_CR);
        send_text("-12,34\"");
        send_text("(l,+-5\"");
        send_text("(l,5");
        send_byte(8'h00);
        send_text("9\"");
        send_text("(n,1(2\"");
        send_text("xyz\"");
        send_text("(s\"");
        send_byte(BYTE_OPEN);
        send_byte(8'hFF);
        send_text(",9\"");
        send_text("(d,");
        for (i = 0; i < BODY_LIMIT - 2; i++)
            send_byte("1");
        send_byte(BYTE_END);
        send_text("(d,");
        for (i = 0; i < BODY_LIMIT - 2; i++)
            send_byte("3");
        send_text("27\"");
    endtask

    task automatic test_back_to_back();
        int stop_at;
        idle_pct = 0;
        stop_at = bytes_taken + 150;
        while (bytes_taken < stop_at)
            send_random_frame();
    endtask

    task automatic test_random_frames();
        int stop_at;
        idle_pct = 26;
        stop_at = bytes_taken + 480;
        while (bytes_taken < stop_at)
            send_random_frame();
        send_byte(BYTE_END);
    endtask

    task automatic drain_and_finish();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("position_frame_parser: match");
        else
            $display("position_frame_parser: mismatch");
        $finish;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_frames();
        test_back_to_back();
        test_random_frames();
        drain_and_finish();
    end

endmodule
